@@ rtl/core/dcc_pkg.sv @@
// dcc_pkg: shared codes, port widths and the sigmoid table for the depthwise
// causal conv1d with silu block. No dependencies.
package dcc_pkg;

    localparam int FUNC_W    = 3;
    localparam int CHAN_W    = 6;
    localparam int TAPF_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    localparam logic [FUNC_W-1:0] FN_SAMPLE    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_W    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOAD_B    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_LOAD_H    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ_H    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;

    localparam logic KIND_FILTER = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam int SIG_N = 128;

    typedef logic [15:0] t_sig_tab [SIG_N];

    // restoring long division, only evaluated while building the table
    function automatic longint unsigned div_u64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // positive half of the q15 sigmoid, steps of 1/16
    function automatic t_sig_tab build_sig_tab();
        t_sig_tab t;
        longint unsigned e;
        longint unsigned e2;
        longint unsigned p;
        longint unsigned den;
        e  = 64'd1040706261;
        e2 = (e * e + (64'd1 << 29)) >> 30;
        p  = e;
        for (int i = 0; i < SIG_N; i++) begin
            den  = (64'd1 << 30) + p;
            t[i] = 16'(div_u64((64'd1 << 45) + (den >> 1), den));
            p    = (p * e2 + (64'd1 << 29)) >> 30;
        end
        return t;
    endfunction

    localparam t_sig_tab SIG_TAB = build_sig_tab();

endpackage

@@ rtl/core/dcc_ram.sv @@
// dcc_ram: generic single write port, single read port ram with registered
// read data. No dependencies.
module dcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/depthwise_causal_conv1d_silu.sv @@
// depthwise_causal_conv1d_silu: top level, per-channel causal fir with history
// and optional silu. Uses dcc_pkg and dcc_ram.
//
// After reset the block sweeps its bias and history memories to zero, one entry
// a cycle, and takes no word meanwhile. For a sample word one shared multiplier
// and one saturating 64-bit adder walk the taps in use, one tap per cycle out of
// the weight and history memories, while the history shifts through the same
// history write port; rounding and saturation follow, and with silu the table
// multiply. Loads write their memory as they are accepted, history reads pass
// through S_RDW. A finished result waits in the output register while the next
// word is accepted.
module depthwise_causal_conv1d_silu #(
    parameter int CHANNELS    = 64,
    parameter int MAX_TAPS    = 32,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [dcc_pkg::FUNC_W-1:0]         i_func,
    input  logic [dcc_pkg::CHAN_W-1:0]         i_channel,
    input  logic [dcc_pkg::TAPF_W-1:0]         i_tap,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_result_value,
    output logic                               o_result_kind,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dcc_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import dcc_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TAP_W = $clog2(MAX_TAPS);
    localparam int AW    = CH_W + TAP_W;
    localparam int KW    = $clog2(MAX_TAPS + 1);
    localparam int MB    = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
    localparam int PW    = SAMPLE_BITS + MB;
    localparam int IW    = SAMPLE_BITS + 10;

    localparam logic signed [63:0] SMAX  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SMIN  = -SMAX - 64'sd1;
    localparam logic signed [63:0] HALF  = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] HALFQ = 64'sd1 <<< 14;
    localparam logic signed [63:0] AMAX  = 64'h7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] AMIN  = 64'h8000_0000_0000_0000;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RUN   = 4'd2;
    localparam logic [3:0] S_ROUND = 4'd3;
    localparam logic [3:0] S_SAT   = 4'd4;
    localparam logic [3:0] S_SMUL  = 4'd5;
    localparam logic [3:0] S_SOUT  = 4'd6;
    localparam logic [3:0] S_RDW   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [63:0] v);
        if (v > SMAX) begin
            return SAMPLE_BITS'(SMAX);
        end else if (v < SMIN) begin
            return SAMPLE_BITS'(SMIN);
        end
        return SAMPLE_BITS'(v);
    endfunction

    logic [3:0]                    r_state, n_state;
    logic [AW-1:0]                 r_clr;
    logic [CFG_DAT_W-1:0]          r_cfg_taps;
    logic                          r_cfg_mode;
    logic [CH_W-1:0]               r_ch;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [KW-1:0]                 r_taps;
    logic [KW-1:0]                 r_k;
    logic                          r_first;
    logic                          r_d1_valid, r_d1_last;
    logic [TAP_W-1:0]              r_d1_k;
    logic                          r_d2_valid, r_d2_last;
    logic signed [PW-1:0]          r_prod;
    logic signed [63:0]            r_acc;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [SAMPLE_BITS-1:0] r_res;
    logic                          r_kind;
    logic                          r_rd_ok;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic                          r_out_kind;

    logic                  in_acc, ch_ok, tapw_ok, taph_ok, issue, out_load;
    logic [CH_W-1:0]       in_ch;
    logic [TAP_W-1:0]      in_tap;
    logic [KW-1:0]         taps_eff;
    logic [AW-1:0]         h_raddr, h_waddr;
    logic                  h_we, w_we, b_we;
    logic [SAMPLE_BITS-1:0] h_wdata, b_wdata, h_rdata, w_rdata, b_rdata;
    logic [CH_W-1:0]       b_waddr;
    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [MB-1:0]  mul_b;
    logic signed [PW-1:0]  mul_p;
    logic signed [63:0]    add_a, add_b, add_s, add_sat;
    logic [IW-1:0]         idx_full;
    logic [7:0]            idx;
    logic [15:0]           sig;

    assign in_acc  = i_valid && o_ready;
    assign ch_ok   = int'(i_channel) < CHANNELS;
    assign tapw_ok = int'(i_tap) < MAX_TAPS;
    assign taph_ok = int'(i_tap) < MAX_TAPS - 1;
    assign in_ch   = CH_W'(i_channel);
    assign in_tap  = TAP_W'(i_tap);
    assign issue   = (r_state == S_RUN) && (r_k < r_taps);
    assign out_load = (r_state == S_FIN) && (!r_out_valid || i_ready);

    always_comb begin
        if (r_cfg_taps == '0) begin
            taps_eff = KW'(1);
        end else if (int'(r_cfg_taps) > MAX_TAPS) begin
            taps_eff = KW'(MAX_TAPS);
        end else begin
            taps_eff = KW'(r_cfg_taps);
        end
    end

    // memory ports
    assign h_raddr = (r_state == S_IDLE) ? {in_ch, in_tap} : {r_ch, r_k[TAP_W-1:0]};

    always_comb begin
        h_we    = 1'b0;
        h_waddr = {in_ch, in_tap};
        h_wdata = i_sample_value;
        w_we    = 1'b0;
        b_we    = 1'b0;
        b_waddr = in_ch;
        b_wdata = i_sample_value;
        if (r_state == S_CLEAR) begin
            h_we    = 1'b1;
            h_waddr = r_clr;
            h_wdata = '0;
            b_we    = 1'b1;
            b_waddr = r_clr[CH_W-1:0];
            b_wdata = '0;
        end else if (r_state == S_IDLE) begin
            w_we = in_acc && (i_func == FN_LOAD_W) && ch_ok && tapw_ok;
            b_we = in_acc && (i_func == FN_LOAD_B) && ch_ok;
            h_we = in_acc && (i_func == FN_LOAD_H) && ch_ok && taph_ok;
        end else if (r_d1_valid && (r_d1_k != '0)) begin
            // shift history down one place, newest sample goes last
            h_we    = 1'b1;
            h_waddr = {r_ch, r_d1_k - TAP_W'(1)};
            h_wdata = r_d1_last ? r_x : h_rdata;
        end
    end

    dcc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(2 ** AW)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    dcc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(2 ** AW)) u_weight (
        .i_clk(i_clk), .i_we(w_we), .i_waddr({in_ch, in_tap}), .i_wdata(i_sample_value),
        .i_raddr(h_raddr), .o_rdata(w_rdata)
    );

    dcc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(2 ** CH_W)) u_bias (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(in_ch), .o_rdata(b_rdata)
    );

    // silu table lookup
    assign idx_full = IW'(IW'($signed(r_y)) >>> (FRAC_BITS - 4)) + IW'(128);
    always_comb begin
        if ($signed(idx_full) < 0) begin
            idx = 8'd0;
        end else if ($signed(idx_full) > 255) begin
            idx = 8'd255;
        end else begin
            idx = idx_full[7:0];
        end
        if (idx[7]) begin
            sig = SIG_TAB[idx[6:0]];
        end else begin
            sig = 16'(17'd32768 - 17'(SIG_TAB[~idx[6:0]]));
        end
    end

    // shared multiplier and adder
    always_comb begin
        if (r_state == S_SMUL) begin
            mul_a = r_y;
            mul_b = MB'($signed({1'b0, sig}));
        end else begin
            mul_a = $signed(w_rdata);
            mul_b = MB'(r_d1_last ? r_x : $signed(h_rdata));
        end
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    always_comb begin
        add_a = (r_state == S_SOUT) ? 64'(r_prod) : r_acc;
        add_b = (r_state == S_ROUND) ? HALF :
                (r_state == S_SOUT) ? HALFQ : 64'(r_prod);
        add_s = add_a + add_b;
        if ((add_a[63] == add_b[63]) && (add_s[63] != add_a[63])) begin
            add_sat = add_a[63] ? AMIN : AMAX;
        end else begin
            add_sat = add_s;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc && ch_ok && (i_func == FN_SAMPLE)) begin
                    n_state = S_RUN;
                end else if (in_acc && (i_func == FN_READ_H)) begin
                    n_state = S_RDW;
                end
            end
            S_RUN: begin
                if (r_d2_valid && r_d2_last) n_state = S_ROUND;
            end
            S_ROUND: n_state = S_SAT;
            S_SAT:   n_state = r_cfg_mode ? S_SMUL : S_FIN;
            S_SMUL:  n_state = S_SOUT;
            S_SOUT:  n_state = S_FIN;
            S_RDW:   n_state = S_FIN;
            S_FIN: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cfg_taps  <= CFG_DAT_W'(4);
            r_cfg_mode  <= 1'b1;
            r_k         <= '0;
            r_first     <= 1'b0;
            r_d1_valid  <= 1'b0;
            r_d2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_TAPS) r_cfg_taps <= i_cfg_data;
                if (i_cfg_index == CFG_MODE) r_cfg_mode <= i_cfg_data[0];
            end
            if (r_state == S_IDLE) begin
                r_k     <= '0;
                r_first <= 1'b1;
            end else if (issue) begin
                r_k     <= r_k + KW'(1);
                r_first <= 1'b0;
            end
            r_d1_valid <= issue;
            r_d2_valid <= r_d1_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_ch    <= in_ch;
            r_x     <= i_sample_value;
            r_taps  <= taps_eff;
            r_rd_ok <= ch_ok && taph_ok;
        end
        r_d1_k    <= r_k[TAP_W-1:0];
        r_d1_last <= (r_k == r_taps - KW'(1));
        r_d2_last <= r_d1_last;
        if (r_d1_valid || (r_state == S_SMUL)) r_prod <= mul_p;
        if ((r_state == S_RUN) && r_first) begin
            r_acc <= 64'($signed(b_rdata)) <<< FRAC_BITS;
        end else if (((r_state == S_RUN) && r_d2_valid) || (r_state == S_ROUND)) begin
            r_acc <= add_sat;
        end
        if (r_state == S_SAT) begin
            r_y    <= sat_s(r_acc >>> FRAC_BITS);
            r_res  <= sat_s(r_acc >>> FRAC_BITS);
            r_kind <= KIND_FILTER;
        end
        if (r_state == S_SOUT) begin
            r_res <= sat_s(add_s >>> 15);
        end
        if (r_state == S_RDW) begin
            r_res  <= r_rd_ok ? $signed(h_rdata) : '0;
            r_kind <= KIND_READ;
        end
        if (out_load) begin
            r_out_value <= r_res;
            r_out_kind  <= r_kind;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_kind  = r_out_kind;

    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ch_ok && (i_func == FN_SAMPLE)) |=> (r_state == S_RUN))
        else $error("sample word did not start the tap walk");

    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_k <= r_taps))
        else $error("tap counter ran past taps in use");

    a_mac_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d2_valid |-> (r_state == S_RUN))
        else $error("product arrived outside the tap walk");
endmodule

@@ verif/tb.sv @@
// tb: self-checking testbench for depthwise_causal_conv1d_silu, directed and
// random words across tap and activation settings and idle patterns.
// Depends on dcc_pkg and the block's rtl.
module tb;
    import dcc_pkg::*;

    localparam int NCH  = 64;
    localparam int NTAP = 32;
    localparam int NHIS = NTAP - 1;
    localparam int NWCH = 8;
    localparam longint LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic [FUNC_W-1:0] i_func;
    logic [CHAN_W-1:0] i_channel;
    logic [TAPF_W-1:0] i_tap;
    logic signed [15:0] i_sample_value;
    logic o_valid;
    logic i_ready;
    logic signed [15:0] o_result_value;
    logic o_result_kind;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    depthwise_causal_conv1d_silu dut (.*);

    typedef struct packed {
        logic signed [15:0] value;
        logic               kind;
    } t_res;

    // predictor state
    logic signed [15:0] coef [NCH*NTAP];
    logic signed [15:0] bias [NCH];
    logic signed [15:0] hist [NCH*NHIS];
    int unsigned        taps_cfg;
    bit                 silu_on;

    t_res   expected_q [$];
    int     mismatches;
    int     results_seen;
    int     words_sent;
    longint cycles;
    int     send_idle_pct;
    int     recv_stall_pct;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint sig_q15(int unsigned k);
        longint unsigned e, e2, p, den;
        e  = 64'd1040706261;
        e2 = (e * e + (64'd1 << 29)) >> 30;
        p  = e;
        for (int unsigned i = 0; i < k; i++)
            p = (p * e2 + (64'd1 << 29)) >> 30;
        den = (64'd1 << 30) + p;
        return longint'(((64'd1 << 45) + den / 2) / den);
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint add_sat64(longint a, longint b);
        longint s;
        s = a + b;
        if (a >= 0 && b >= 0 && s < 0) return 64'sh7fffffffffffffff;
        if (a < 0 && b < 0 && s >= 0) return 64'sh8000000000000000;
        return s;
    endfunction

    function automatic longint apply_silu(longint y);
        longint idx, sg;
        idx = (y >>> 8) + 128;
        if (idx < 0) idx = 0;
        if (idx > 255) idx = 255;
        if (idx >= 128) sg = sig_q15(idx - 128);
        else sg = 32768 - sig_q15(127 - idx);
        return clamp16((y * sg + (64'sd1 << 14)) >>> 15);
    endfunction

    // updates the predicted state and returns whether a result is produced
    function automatic bit predict_word(logic [2:0] fn, int ch, int tp,
                                        logic signed [15:0] x, output t_res r);
        int unsigned k;
        longint acc, y;
        r = '0;
        case (fn)
            FN_SAMPLE: begin
                k = taps_cfg == 0 ? 1 : (taps_cfg > NTAP ? NTAP : taps_cfg);
                acc = longint'(bias[ch]) <<< 12;
                for (int i = 0; i + 1 < k; i++)
                    acc = add_sat64(acc, longint'(coef[ch*NTAP+i]) * hist[ch*NHIS+i]);
                acc = add_sat64(acc, longint'(coef[ch*NTAP+k-1]) * x);
                acc = add_sat64(acc, 64'sd2048);
                y = clamp16(acc >>> 12);
                if (silu_on) y = apply_silu(y);
                if (k >= 2) begin
                    for (int i = 0; i + 2 < k; i++)
                        hist[ch*NHIS+i] = hist[ch*NHIS+i+1];
                    hist[ch*NHIS+k-2] = x;
                end
                r.value = 16'(y);
                r.kind = KIND_FILTER;
                return 1;
            end
            FN_LOAD_W: coef[ch*NTAP+tp] = x;
            FN_LOAD_B: bias[ch] = x;
            FN_LOAD_H: if (tp < NHIS) hist[ch*NHIS+tp] = x;
            FN_READ_H: begin
                r.value = tp < NHIS ? hist[ch*NHIS+tp] : 16'sd0;
                r.kind = KIND_READ;
                return 1;
            end
            default: ;
        endcase
        return 0;
    endfunction

    task automatic send_word(logic [2:0] fn, int ch, int tp, logic signed [15:0] x);
        t_res r;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= fn;
        i_channel      <= CHAN_W'(ch);
        i_tap          <= TAPF_W'(tp);
        i_sample_value <= x;
        do @(posedge i_clk); while (!o_ready);
        if (predict_word(fn, ch, tp, x, r)) expected_q.push_back(r);
        words_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %0d", o_result_value);
                end else begin
                    t_res e;
                    e = expected_q.pop_front();
                    if (e.value !== o_result_value || e.kind !== o_result_kind) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0b got %0d/%0b", e.value,
                                     e.kind, o_result_value, o_result_kind);
                    end
                end
            end
            i_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DAT_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TAPS) taps_cfg = val;
        else silu_on = val[0];
    endtask

    // channels whose weights are all loaded: 0..NWCH-1 and the last one
    function automatic int sample_ch();
        int c;
        c = $urandom_range(NWCH);
        return (c == NWCH) ? NCH - 1 : c;
    endfunction

    task automatic load_all_weights();
        for (int c = 0; c <= NWCH; c++)
            for (int t = 0; t < NTAP; t++)
                send_word(FN_LOAD_W, (c == NWCH) ? NCH - 1 : c, t,
                          16'($urandom_range(2048) - 1024));
    endtask

    function automatic logic signed [15:0] rand_val();
        case ($urandom_range(3))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom);
            default: return 16'($urandom_range(8191) - 4096);
        endcase
    endfunction

    task automatic test_directed();
        load_all_weights();
        send_word(FN_LOAD_B, 0, 0, 16'sh7fff);
        send_word(FN_LOAD_B, 63, 0, 16'sh8000);
        send_word(FN_LOAD_H, 0, 30, 16'sh1234);
        send_word(FN_LOAD_H, 0, 31, 16'sh4321);
        send_word(FN_READ_H, 0, 30, 0);
        send_word(FN_READ_H, 0, 31, 0);
        send_word(FN_LOAD_W, 1, 3, 16'sh7fff);
        send_word(FN_LOAD_W, 1, 2, 16'sh8000);
        send_word(FN_SAMPLE, 1, 0, 16'sh7fff);
        send_word(FN_SAMPLE, 1, 31, 16'sh8000);
        send_word(FN_SAMPLE, 63, 0, 16'sh1000);
        send_word(FN_SAMPLE, 0, 0, 16'sh0000);
        send_word(3'd5, 2, 1, 16'sh5555);
        send_word(3'd6, 2, 1, 16'sh5555);
        send_word(3'd7, 2, 1, 16'sh5555);
        send_word(FN_READ_H, 1, 2, 0);
        send_word(FN_READ_H, 63, 0, 0);
    endtask

    task automatic test_random(int n, int taps, int mode);
        int c;
        write_cfg(CFG_TAPS, taps);
        write_cfg(CFG_MODE, mode);
        for (int i = 0; i < n; i++) begin
            c = sample_ch();
            case ($urandom_range(19))
                0, 1:  send_word(FN_LOAD_W, c, $urandom_range(31), rand_val());
                2:     send_word(FN_LOAD_B, c, 0, rand_val());
                3:     send_word(FN_LOAD_H, c, $urandom_range(31), rand_val());
                4, 5:  send_word(FN_READ_H, c, $urandom_range(31), 0);
                6:     send_word(3'($urandom_range(7, 5)), c, $urandom_range(31), rand_val());
                default: send_word(FN_SAMPLE, c, $urandom_range(31), rand_val());
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0; i_cfg_valid = 1'b0;
        i_func = '0; i_channel = '0; i_tap = '0; i_sample_value = '0;
        i_cfg_index = '0; i_cfg_data = '0;
        cycles = 0; mismatches = 0; results_seen = 0; words_sent = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        taps_cfg = 4; silu_on = 1;
        foreach (bias[i]) bias[i] = 0;
        foreach (hist[i]) hist[i] = 0;
        foreach (coef[i]) coef[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(110, 1, 0);
        send_idle_pct = 48;
        test_random(110, 32, 1);
        send_idle_pct = 0; recv_stall_pct = 48;
        test_random(110, 0, 1);
        send_idle_pct = 35; recv_stall_pct = 35;
        test_random(110, 63, 0);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random(110, 2, 1);
        send_idle_pct = 48;
        test_random(110, 17, 0);
        send_idle_pct = 35; recv_stall_pct = 35;
        test_random(110, 4, 1);
        send_idle_pct = 0; recv_stall_pct = 48;
        test_random(110, 31, 1);
        drain();
        $display("covered %0d words, %0d results, tap counts 0..63, silu on/off",
                 words_sent, results_seen);
        if (mismatches == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
